// ===== rtl/bve_pkg.sv =====
`default_nettype none

package bve_pkg;

    localparam int WORD_W = 32;

    typedef logic [WORD_W-1:0] word_t;

    // request codes
    typedef enum logic [2:0] {
        OP_APPEND       = 3'd0,
        OP_INSERT_FRONT = 3'd1,
        OP_WRITE        = 3'd2,
        OP_READ         = 3'd3,
        OP_REMOVE_FIRST = 3'd4,
        OP_REMOVE_LAST  = 3'd5,
        OP_REVERSE      = 3'd6,
        OP_REMOVE_AT    = 3'd7
    } op_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    // what a cell does with its word at the next edge
    typedef enum logic [1:0] {
        CELL_HOLD       = 2'd0,
        CELL_LOAD       = 2'd1,
        CELL_TAKE_LEFT  = 2'd2,
        CELL_TAKE_RIGHT = 2'd3
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t cmd;
        logic      lane_load;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/bve_cell.sv =====
`default_nettype none

module bve_cell (
    input  wire logic               clk,
    input  wire bve_pkg::cell_ctrl_t ctrl,
    input  wire bve_pkg::word_t     load_word,
    input  wire bve_pkg::word_t     left_word,
    input  wire bve_pkg::word_t     right_word,
    input  wire bve_pkg::word_t     lane_in,
    output bve_pkg::word_t          word,
    output bve_pkg::word_t          lane
);

    bve_pkg::word_t word_reg;
    bve_pkg::word_t word_next;
    bve_pkg::word_t lane_reg;
    bve_pkg::word_t lane_next;

    always_comb
    begin
        case (ctrl.cmd)
            bve_pkg::CELL_LOAD:       word_next = load_word;
            bve_pkg::CELL_TAKE_LEFT:  word_next = left_word;
            bve_pkg::CELL_TAKE_RIGHT: word_next = right_word;
            default:                  word_next = word_reg;
        endcase
    end

    // read lane: snapshot of the stored word, then shifts toward cell 0
    assign lane_next = ctrl.lane_load ? word_reg : lane_in;

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        lane_reg <= lane_next;
    end

    assign word = word_reg;
    assign lane = lane_reg;

endmodule

`default_nettype wire

// ===== rtl/bounded_vector_engine_unit.sv =====
`default_nettype none

// Fixed-capacity ordered list of 32-bit words held in a row of DEPTH word cells, cell 0 being
// the front. A request (op, position, write_value) is taken when start is high and busy is
// low; its result word (read_value, status, entry_count) appears for exactly one cycle with
// done high and cannot be held off, so the receiver must capture it then. Append, insert
// front, write, remove first, remove last and remove at act at the accepting edge, where the
// cells involved move their words to a neighbor or load write_value; busy stays low and done
// follows in the next cycle; the next request may be issued in that same done cycle. A read
// at position p keeps busy high while the cells' words, copied into a read lane at the
// accepting edge, shift one cell toward the front per cycle until the word of position p
// reaches the front, with done in the cycle after that. A reverse of n entries (n > 1) keeps
// busy high for n odd-even neighbor exchange rounds over the row, with done in the cycle
// after the last round. Errors (full, out of range, empty) leave the list unchanged.
// capacity_limit (APB, byte address 0, 5 bits, reset 16) bounds the count; values above
// DEPTH act as DEPTH, and it may only be written while the block is idle.
module bounded_vector_engine_unit #(
    parameter int DEPTH = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // request side
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic [2:0]                       op,
    input  wire logic [$clog2(DEPTH)-1:0]         position,
    input  wire logic [31:0]                      write_value,
    // result side
    output logic                                  done,
    output logic [31:0]                           read_value,
    output logic [1:0]                            status,
    output logic [$clog2(DEPTH+1)-1:0]            entry_count,
    // configuration port
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [2:0]                       paddr,
    input  wire logic [31:0]                      pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);

    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int CAP_W     = 5;
    localparam int EXT_W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
    localparam logic [EXT_W-1:0] DEPTH_EXT = EXT_W'(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE    = 3'b001,
        S_REVERSE = 3'b010,
        S_READ    = 3'b100
    } state_t;

    // control state
    state_t                state_reg;
    state_t                state_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [CNT_W-1:0]      step_reg;     // reverse round or read countdown
    logic [CNT_W-1:0]      step_next;
    logic [CAP_W-1:0]      cap_reg;
    logic                  done_reg;
    logic                  done_next;

    // result word
    bve_pkg::status_t      status_reg;
    bve_pkg::status_t      status_next;
    bve_pkg::word_t        read_value_reg;
    bve_pkg::word_t        read_value_next;

    logic                  accept;
    logic                  cfg_write;
    bve_pkg::op_t          op_in;
    logic [CNT_W-1:0]      pos_ext;
    logic [CNT_W-1:0]      eff_cap;

    bve_pkg::word_t        cell_word [DEPTH];
    bve_pkg::word_t        cell_lane [DEPTH];
    bve_pkg::cell_ctrl_t   cell_ctrl [DEPTH];

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign op_in     = bve_pkg::op_t'(op);
    assign pos_ext   = CNT_W'(position);
    // limit above the row length acts as the row length
    assign eff_cap   = (EXT_W'(cap_reg) > DEPTH_EXT) ? DEPTH_CNT : CNT_W'(cap_reg);

    // configuration port: one register, always ready
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata    = (paddr[2] == 1'b0) ? {{(32 - CAP_W){1'b0}}, cap_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_write)
        begin
            cap_reg <= pwdata[CAP_W-1:0];
        end
    end

    // request decode and cell commands
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        step_next       = step_reg;
        done_next       = 1'b0;
        status_next     = status_reg;
        read_value_next = read_value_reg;
        for (int i = 0; i < DEPTH; i++)
        begin
            cell_ctrl[i].cmd       = bve_pkg::CELL_HOLD;
            cell_ctrl[i].lane_load = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    done_next       = 1'b1;
                    status_next     = bve_pkg::ST_OK;
                    read_value_next = '0;
                    unique case (op_in)
                        bve_pkg::OP_APPEND:
                        begin
                            if (count_reg >= eff_cap)
                            begin
                                status_next = bve_pkg::ST_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + 1'b1;
                                for (int i = 0; i < DEPTH; i++)
                                begin
                                    if (CNT_W'(i) == count_reg)
                                    begin
                                        cell_ctrl[i].cmd = bve_pkg::CELL_LOAD;
                                    end
                                end
                            end
                        end
                        bve_pkg::OP_INSERT_FRONT:
                        begin
                            if (count_reg >= eff_cap)
                            begin
                                status_next = bve_pkg::ST_FULL;
                            end
                            else
                            begin
                                count_next       = count_reg + 1'b1;
                                cell_ctrl[0].cmd = bve_pkg::CELL_LOAD;
                                for (int i = 1; i < DEPTH; i++)
                                begin
                                    if (CNT_W'(i) <= count_reg)
                                    begin
                                        cell_ctrl[i].cmd = bve_pkg::CELL_TAKE_LEFT;
                                    end
                                end
                            end
                        end
                        bve_pkg::OP_WRITE:
                        begin
                            if (pos_ext >= count_reg)
                            begin
                                status_next = bve_pkg::ST_RANGE;
                            end
                            else
                            begin
                                for (int i = 0; i < DEPTH; i++)
                                begin
                                    if (CNT_W'(i) == pos_ext)
                                    begin
                                        cell_ctrl[i].cmd = bve_pkg::CELL_LOAD;
                                    end
                                end
                            end
                        end
                        bve_pkg::OP_READ:
                        begin
                            if (pos_ext >= count_reg)
                            begin
                                status_next = bve_pkg::ST_RANGE;
                            end
                            else
                            begin
                                done_next  = 1'b0;
                                state_next = S_READ;
                                step_next  = pos_ext;
                                for (int i = 0; i < DEPTH; i++)
                                begin
                                    cell_ctrl[i].lane_load = 1'b1;
                                end
                            end
                        end
                        bve_pkg::OP_REMOVE_FIRST:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = bve_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                                for (int i = 0; i < DEPTH - 1; i++)
                                begin
                                    if (CNT_W'(i + 1) < count_reg)
                                    begin
                                        cell_ctrl[i].cmd = bve_pkg::CELL_TAKE_RIGHT;
                                    end
                                end
                            end
                        end
                        bve_pkg::OP_REMOVE_LAST:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = bve_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        bve_pkg::OP_REVERSE:
                        begin
                            if (count_reg > CNT_W'(1))
                            begin
                                done_next  = 1'b0;
                                state_next = S_REVERSE;
                                step_next  = '0;
                            end
                        end
                        bve_pkg::OP_REMOVE_AT:
                        begin
                            if (pos_ext >= count_reg)
                            begin
                                status_next = bve_pkg::ST_RANGE;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                                for (int i = 0; i < DEPTH - 1; i++)
                                begin
                                    if ((CNT_W'(i) >= pos_ext) && (CNT_W'(i + 1) < count_reg))
                                    begin
                                        cell_ctrl[i].cmd = bve_pkg::CELL_TAKE_RIGHT;
                                    end
                                end
                            end
                        end
                        default:
                        begin
                            status_next = bve_pkg::ST_OK;
                        end
                    endcase
                end
            end

            S_REVERSE:
            begin
                // odd-even exchange: pairs start at cells whose index parity matches the round
                for (int i = 0; i < DEPTH - 1; i++)
                begin
                    if ((1'(i) == step_reg[0]) && (CNT_W'(i + 1) < count_reg))
                    begin
                        cell_ctrl[i].cmd     = bve_pkg::CELL_TAKE_RIGHT;
                        cell_ctrl[i + 1].cmd = bve_pkg::CELL_TAKE_LEFT;
                    end
                end
                if (step_reg == count_reg - 1'b1)
                begin
                    done_next       = 1'b1;
                    status_next     = bve_pkg::ST_OK;
                    read_value_next = '0;
                    state_next      = S_IDLE;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end

            S_READ:
            begin
                // lane shifts one cell per cycle; front of the lane holds the word once at zero
                if (step_reg == '0)
                begin
                    done_next       = 1'b1;
                    status_next     = bve_pkg::ST_OK;
                    read_value_next = cell_lane[0];
                    state_next      = S_IDLE;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg     <= status_next;
        read_value_reg <= read_value_next;
    end

    // row of word cells, cell 0 at the front
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        bve_pkg::word_t left_word;
        bve_pkg::word_t right_word;
        bve_pkg::word_t lane_in;

        if (g == 0)
        begin : g_front
            assign left_word = '0;
        end
        else
        begin : g_inner_left
            assign left_word = cell_word[g - 1];
        end

        if (g == DEPTH - 1)
        begin : g_back
            assign right_word = '0;
            assign lane_in    = '0;
        end
        else
        begin : g_inner_right
            assign right_word = cell_word[g + 1];
            assign lane_in    = cell_lane[g + 1];
        end

        bve_cell u_cell (
            .clk        (clk),
            .ctrl       (cell_ctrl[g]),
            .load_word  (write_value),
            .left_word  (left_word),
            .right_word (right_word),
            .lane_in    (lane_in),
            .word       (cell_word[g]),
            .lane       (cell_lane[g])
        );
    end

    // result word
    assign done        = done_reg;
    assign read_value  = read_value_reg;
    assign status      = status_reg;
    assign entry_count = count_reg;

    // a successful append grows the list by exactly one entry
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (op_in == bve_pkg::OP_APPEND) && (count_reg < eff_cap))
        |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("append did not grow the count by one");

    // no result word is shown while a multi-cycle request is still running
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !done_reg)
        else $error("result strobe during a running request");

    // failed requests always report a zero read word
    assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (status_reg != bve_pkg::ST_OK)) |-> (read_value_reg == '0))
        else $error("error result carries a nonzero read word");

    // the count never passes the row length
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (count_reg <= DEPTH_CNT))
        else $error("entry count beyond the row length");

endmodule

`default_nettype wire
